>>> hdl/stok_pkg.sv
// shared types and constants for the script tokenizer
package stok_pkg;

	localparam int unsigned LEN_W     = 10;
	localparam int unsigned LINE_W    = 20;
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QAW       = $clog2(QDEPTH);
	localparam int unsigned SLOTS     = 3;

	localparam logic [LEN_W-1:0]  MAX_LEN_RST = 10'd1023;
	localparam logic [LINE_W-1:0] LINE_MAX    = 20'hFFFFF;

	localparam logic [7:0] CH_EOI   = 8'd0;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_EOI  = 2'd2
	} kind_t;

	typedef enum logic [6:0] {
		MODE_IDLE  = 7'b0000001,
		MODE_SLASH = 7'b0000010,
		MODE_LINE  = 7'b0000100,
		MODE_BLOCK = 7'b0001000,
		MODE_STAR  = 7'b0010000,
		MODE_QUOTE = 7'b0100000,
		MODE_WORD  = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        token_byte;
		logic [LINE_W-1:0] token_line;
		logic              is_quoted;
		logic              truncated;
	} res_t;

	// up to three results caused by one text byte, slot 0 first
	typedef struct packed {
		logic [1:0]       cnt;
		res_t [SLOTS-1:0] r;
	} bundle_t;

endpackage

>>> hdl/stok_in_if.sv
// text byte channel
interface stok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

>>> hdl/stok_out_if.sv
// token result channel
interface stok_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  token_byte;
	logic [19:0] token_line;
	logic        is_quoted;
	logic        truncated;
	logic        last;

	modport source (output valid, output kind, output token_byte, output token_line,
		output is_quoted, output truncated, output last, input ready);
	modport sink (input valid, input kind, input token_byte, input token_line,
		input is_quoted, input truncated, input last, output ready);
endinterface

>>> hdl/script_tokenizer_unit.sv
// script tokenizer top: front scanner, bundle queue, result serializer
// the results of a byte pass through the bundle queue and then the output register before they are valid
// one text byte per cycle while the queue is not full; the output register moves one result per cycle
//   while tokens.ready is high, so a byte that causes k results (k up to 3) takes k output beats
// the four-entry bundle queue lets the front keep taking bytes while results wait
// reset: arst_n clears scan state, line count and queue; the token length limit max_len_q returns to 1023
module script_tokenizer_unit
	import stok_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	stok_in_if.sink          text,
	stok_out_if.source       tokens,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata
);

	logic          push, pop, q_empty, q_full;
	bundle_t       push_data, head;
	logic [QAW:0]  q_level;

	stok_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	stok_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full),
		.level     (q_level)
	);

	stok_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.tokens  (tokens)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= (QAW+1)'(QDEPTH))
		else $error("bundle queue over depth");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_data.cnt != 2'd0))
		else $error("empty bundle pushed");

	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tokens.valid && tokens.kind == KIND_EOI) |-> tokens.last)
		else $error("input end not marked last");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("push into full queue");

endmodule

>>> hdl/stok_front.sv
// front end: scan state machine, builds the result bundle for each text byte
module stok_front
	import stok_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	stok_in_if.sink           text,
	input  logic              cfg_we,
	input  logic [LEN_W-1:0]  cfg_wdata,
	input  logic              q_full,
	output logic              push,
	output bundle_t           push_data
);

	mode_t             mode_q, mode_d;
	logic [LINE_W-1:0] line_q, line_d;
	logic [LINE_W-1:0] start_q, start_d;
	logic [LEN_W-1:0]  kept_q, kept_d;
	logic              drop_q, drop_d;
	logic [LEN_W-1:0]  max_len_q;

	logic              acc;
	logic [7:0]        b;
	logic              b_space;
	logic              do_begin, add_a, add_b, end_en, fin;
	logic              b_quoted, end_quoted;
	logic [LEN_W-1:0]  base_kept, kept1;
	logic              base_drop, drop1, drop2;
	logic              a_ok, b_ok;
	logic [LINE_W-1:0] tok_line;
	res_t [3:0]        cand;
	logic [3:0]        cand_en;
	logic [2:0]        n;
	bundle_t           bun;

	assign b       = text.in_byte;
	assign acc     = text.valid && text.ready;
	assign b_space = b inside {[8'd1:CH_SPACE], [8'd128:8'd255]};

	assign text.ready = !q_full;

	// action decode
	always_comb begin
		mode_d     = mode_q;
		do_begin   = 1'b0;
		add_a      = 1'b0;
		add_b      = 1'b0;
		end_en     = 1'b0;
		fin        = 1'b0;
		b_quoted   = 1'b0;
		end_quoted = 1'b0;
		case (mode_q)
			MODE_SLASH: begin
				if (b == CH_SLASH) begin
					mode_d = MODE_LINE;
				end else if (b == CH_STAR) begin
					mode_d = MODE_BLOCK;
				end else begin
					// lone slash starts a bare word, this byte continues or ends it
					mode_d = MODE_WORD;
					add_a  = 1'b1;
					if (b == CH_EOI) begin
						end_en = 1'b1;
						fin    = 1'b1;
					end else if (b_space) begin
						end_en = 1'b1;
						mode_d = MODE_IDLE;
					end else begin
						add_b = 1'b1;
					end
				end
			end
			MODE_LINE: begin
				if (b == CH_EOI) fin = 1'b1;
				else if (b == CH_NL) mode_d = MODE_IDLE;
			end
			MODE_BLOCK: begin
				if (b == CH_EOI) fin = 1'b1;
				else if (b == CH_STAR) mode_d = MODE_STAR;
			end
			MODE_STAR: begin
				if (b == CH_EOI) fin = 1'b1;
				else if (b == CH_SLASH) mode_d = MODE_IDLE;
				else if (b != CH_STAR) mode_d = MODE_BLOCK;
			end
			MODE_QUOTE: begin
				end_quoted = 1'b1;
				b_quoted   = 1'b1;
				if (b == CH_EOI) begin
					end_en = 1'b1;
					fin    = 1'b1;
				end else if (b == CH_QUOTE) begin
					end_en = 1'b1;
					mode_d = MODE_IDLE;
				end else begin
					add_b = 1'b1;
				end
			end
			MODE_WORD: begin
				if (b == CH_EOI) begin
					end_en = 1'b1;
					fin    = 1'b1;
				end else if (b_space) begin
					end_en = 1'b1;
					mode_d = MODE_IDLE;
				end else begin
					add_b = 1'b1;
				end
			end
			default: begin
				if (b == CH_EOI) begin
					fin = 1'b1;
				end else if (b_space) begin
					mode_d = MODE_IDLE;
				end else if (b == CH_QUOTE) begin
					do_begin = 1'b1;
					mode_d   = MODE_QUOTE;
				end else if (b == CH_SLASH) begin
					do_begin = 1'b1;
					mode_d   = MODE_SLASH;
				end else begin
					do_begin = 1'b1;
					mode_d   = MODE_WORD;
					add_b    = 1'b1;
				end
			end
		endcase
	end

	// length limit and state update
	always_comb begin
		base_kept = do_begin ? '0 : kept_q;
		base_drop = do_begin ? 1'b0 : drop_q;
		tok_line  = do_begin ? line_q : start_q;
		a_ok      = add_a && (base_kept < max_len_q);
		kept1     = base_kept + LEN_W'(a_ok);
		drop1     = base_drop | (add_a & !a_ok);
		b_ok      = add_b && (kept1 < max_len_q);
		kept_d    = kept1 + LEN_W'(b_ok);
		drop2     = drop1 | (add_b & !b_ok);
		drop_d    = drop2;
		start_d   = tok_line;
		line_d    = line_q;
		if (fin) begin
			kept_d  = '0;
			drop_d  = 1'b0;
			start_d = '0;
			line_d  = '0;
		end
		if (b == CH_NL && line_q != LINE_MAX) line_d = line_q + 1'b1;
	end

	// pack the enabled results into consecutive slots
	always_comb begin
		cand[0] = '{kind: KIND_BYTE, token_byte: CH_SLASH, token_line: tok_line,
			is_quoted: 1'b0, truncated: 1'b0};
		cand[1] = '{kind: KIND_BYTE, token_byte: b, token_line: tok_line,
			is_quoted: b_quoted, truncated: 1'b0};
		cand[2] = '{kind: KIND_END, token_byte: 8'd0, token_line: tok_line,
			is_quoted: end_quoted, truncated: drop2};
		cand[3] = '{kind: KIND_EOI, token_byte: 8'd0, token_line: '0,
			is_quoted: 1'b0, truncated: 1'b0};
		cand_en = {fin, end_en, b_ok, a_ok};
		bun = '0;
		n   = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand_en[i]) begin
				if (n < 3'(SLOTS)) bun.r[n[1:0]] = cand[i];
				n = n + 3'd1;
			end
		end
		bun.cnt = n[1:0];
	end

	assign push      = acc && (n != 3'd0);
	assign push_data = bun;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			line_q    <= '0;
			start_q   <= '0;
			kept_q    <= '0;
			drop_q    <= 1'b0;
			max_len_q <= MAX_LEN_RST;
		end else begin
			if (acc) begin
				mode_q  <= fin ? MODE_IDLE : mode_d;
				line_q  <= line_d;
				start_q <= start_d;
				kept_q  <= kept_d;
				drop_q  <= drop_d;
			end
			if (cfg_we) max_len_q <= cfg_wdata;
		end
	end

endmodule

>>> hdl/stok_queue.sv
// small bundle fifo between front and back
module stok_queue
	import stok_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bundle_t        push_data,
	input  logic           pop,
	output bundle_t        head,
	output logic           empty,
	output logic           full,
	output logic [QAW:0]   level
);

	bundle_t          mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     level_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (level_q == '0);
	assign full  = (level_q == (QAW+1)'(QDEPTH));
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

>>> hdl/stok_back.sv
// back end: walks the slots of each bundle into the output register
module stok_back
	import stok_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     head,
	input  logic        q_empty,
	output logic        pop,
	stok_out_if.source  tokens
);

	logic [1:0] sel_q;
	logic       valid_q;
	res_t       res_q;
	logic       last_q;
	logic       load;
	logic       at_last;

	assign load    = !q_empty && (!valid_q || tokens.ready);
	assign at_last = (sel_q == head.cnt - 2'd1);
	assign pop     = load && at_last;

	assign tokens.valid      = valid_q;
	assign tokens.kind       = res_q.kind;
	assign tokens.token_byte = res_q.token_byte;
	assign tokens.token_line = res_q.token_line;
	assign tokens.is_quoted  = res_q.is_quoted;
	assign tokens.truncated  = res_q.truncated;
	assign tokens.last       = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= head.r[sel_q];
			last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= at_last ? 2'd0 : sel_q + 2'd1;
			end else if (tokens.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sim/script_tokenizer_unit_checker.sv
// result checker for the script tokenizer: predicts token results from text beats and compares
module stok_result_checker
	import stok_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	stok_in_if               text,
	stok_out_if              tokens,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending,
	output int               checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        tbyte;
		logic [LINE_W-1:0] line;
		logic              quoted;
		logic              trunc;
		logic              last;
	} token_res_t;

	token_res_t        expected_tokens[$];
	token_res_t        want;
	mode_t             scan;
	logic [LINE_W-1:0] line_cnt;
	logic [LINE_W-1:0] tok_line;
	logic [LEN_W-1:0]  kept;
	logic [LEN_W-1:0]  keep_limit;
	logic              dropped;
	int                errs;
	int                n_checked;

	task automatic report_mismatch(input string msg);
		if (errs < 30)
			$display("[%0t] mismatch: %s", $realtime, msg);
		errs++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
		input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("result %0d: %s is 0x%0h, predicted 0x%0h",
				n_checked, name, got, exp_val));
	endtask

	function automatic bit is_blank(input logic [7:0] b);
		return (b >= 8'd1 && b <= 8'd32) || b >= 8'd128;
	endfunction

	task automatic push_res(input kind_t k, input logic [7:0] b, input logic [LINE_W-1:0] ln,
		input logic q, input logic t);
		token_res_t r;
		r.kind = k;
		r.tbyte = b;
		r.line = ln;
		r.quoted = q;
		r.trunc = t;
		r.last = 1'b0;
		expected_tokens.push_back(r);
	endtask

	task automatic open_token();
		tok_line = line_cnt;
		kept = '0;
		dropped = 1'b0;
	endtask

	task automatic keep_byte(input logic [7:0] b, input logic q);
		// keep_limit is 10 bits wide, so it never exceeds 1023
		if (kept < keep_limit) begin
			push_res(KIND_BYTE, b, tok_line, q, 1'b0);
			kept++;
		end else begin
			dropped = 1'b1;
		end
	endtask

	task automatic close_token(input logic q);
		push_res(KIND_END, 8'd0, tok_line, q, dropped);
	endtask

	task automatic end_of_text();
		push_res(KIND_EOI, 8'd0, '0, 1'b0, 1'b0);
		scan = MODE_IDLE;
		line_cnt = '0;
		tok_line = '0;
		kept = '0;
		dropped = 1'b0;
	endtask

	task automatic word_step(input logic [7:0] b);
		if (b == CH_EOI) begin
			close_token(1'b0);
			end_of_text();
		end else if (is_blank(b)) begin
			close_token(1'b0);
			scan = MODE_IDLE;
		end else begin
			keep_byte(b, 1'b0);
		end
	endtask

	task automatic scan_text_byte(input logic [7:0] b);
		int n0;
		n0 = expected_tokens.size();
		case (scan)
			MODE_SLASH: begin
				if (b == CH_SLASH) begin
					scan = MODE_LINE;
				end else if (b == CH_STAR) begin
					scan = MODE_BLOCK;
				end else begin
					// held slash turns out to start a bare word
					scan = MODE_WORD;
					keep_byte(CH_SLASH, 1'b0);
					word_step(b);
				end
			end
			MODE_LINE: begin
				if (b == CH_EOI)
					end_of_text();
				else if (b == CH_NL)
					scan = MODE_IDLE;
			end
			MODE_BLOCK: begin
				if (b == CH_EOI)
					end_of_text();
				else if (b == CH_STAR)
					scan = MODE_STAR;
			end
			MODE_STAR: begin
				if (b == CH_EOI)
					end_of_text();
				else if (b == CH_SLASH)
					scan = MODE_IDLE;
				else if (b != CH_STAR)
					scan = MODE_BLOCK;
			end
			MODE_QUOTE: begin
				if (b == CH_EOI) begin
					close_token(1'b1);
					end_of_text();
				end else if (b == CH_QUOTE) begin
					close_token(1'b1);
					scan = MODE_IDLE;
				end else begin
					keep_byte(b, 1'b1);
				end
			end
			MODE_WORD: begin
				word_step(b);
			end
			default: begin
				if (b == CH_EOI) begin
					end_of_text();
				end else if (is_blank(b)) begin
					scan = MODE_IDLE;
				end else if (b == CH_QUOTE) begin
					open_token();
					scan = MODE_QUOTE;
				end else if (b == CH_SLASH) begin
					open_token();
					scan = MODE_SLASH;
				end else begin
					open_token();
					scan = MODE_WORD;
					keep_byte(b, 1'b0);
				end
			end
		endcase
		// every newline counts up to LINE_MAX, inside tokens and comments too
		if (b == CH_NL && line_cnt != LINE_MAX)
			line_cnt++;
		if (expected_tokens.size() > n0)
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_tokens.delete();
			scan = MODE_IDLE;
			line_cnt = '0;
			tok_line = '0;
			kept = '0;
			dropped = 1'b0;
			keep_limit = MAX_LEN_RST;
			errs = 0;
			n_checked = 0;
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// results of a byte pass through the queue and the output register, so retire before predicting
			if (tokens.valid && tokens.ready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch($sformatf("result of kind %0d with nothing predicted",
						tokens.kind));
				end else begin
					want = expected_tokens.pop_front();
					compare_field("kind", 32'(tokens.kind), 32'(want.kind));
					compare_field("token_byte", 32'(tokens.token_byte), 32'(want.tbyte));
					compare_field("token_line", 32'(tokens.token_line), 32'(want.line));
					compare_field("is_quoted", 32'(tokens.is_quoted), 32'(want.quoted));
					compare_field("truncated", 32'(tokens.truncated), 32'(want.trunc));
					compare_field("last", 32'(tokens.last), 32'(want.last));
				end
				n_checked++;
			end
			if (cfg_we)
				keep_limit = cfg_wdata;
			if (text.valid && text.ready)
				scan_text_byte(text.in_byte);
			fail_count <= errs;
			pending <= expected_tokens.size();
			checked <= n_checked;
		end
	end

endmodule

>>> sim/script_tokenizer_unit_test.sv
// testbench top for the script tokenizer: clock, reset, text stimulus, back-pressure, verdict
module script_tokenizer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import stok_pkg::*;

	localparam int IDLE_LIMIT     = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 16;
	localparam int BYTES_PER_PASS = 45;
	localparam int N_PASSES       = 6;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_BLOCKS,
		RX_LIGHT
	} stall_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;
	int               checked;

	logic [7:0]       text_bytes[$];
	logic [LEN_W-1:0] limit_plan[N_PASSES];
	int               bytes_sent;
	int               burst_left;
	int               idle_cycles;

	stok_in_if  text_ch();
	stok_out_if tok_ch();

	script_tokenizer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text_ch),
		.tokens    (tok_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	stok_result_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.tokens     (tok_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// result side back-pressure with a randomly switching pattern
	initial begin
		stall_t stall_mode;
		int     mode_left;
		int     hold;
		stall_mode = RX_FREE;
		mode_left = 0;
		hold = 0;
		tok_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				stall_mode = stall_t'($urandom_range(0, 3));
				mode_left = $urandom_range(40, 200);
			end
			mode_left--;
			case (stall_mode)
				RX_FREE: begin
					tok_ch.ready <= 1'b1;
				end
				RX_COIN: begin
					tok_ch.ready <= ($urandom_range(0, 1) == 1);
				end
				RX_BLOCKS: begin
					if (hold > 0) begin
						hold--;
						tok_ch.ready <= 1'b0;
					end else if ($urandom_range(0, 15) == 0) begin
						hold = $urandom_range(1, 8);
						tok_ch.ready <= 1'b0;
					end else begin
						tok_ch.ready <= 1'b1;
					end
				end
				default: begin
					tok_ch.ready <= ($urandom_range(0, 3) != 0);
				end
			endcase
		end
	end

	// cycles without any beat on either channel
	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (tok_ch.valid && tok_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no beat for %0d cycles, %0d results outstanding", idle_cycles, pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_NL;
			2: return 8'($urandom_range(1, 32));
			default: return 8'($urandom_range(128, 255));
		endcase
	endfunction

	function automatic logic [7:0] rand_word_byte();
		return 8'($urandom_range(33, 127));
	endfunction

	// mostly short tokens, sometimes just past a small limit
	function automatic int tok_len(input int lim);
		if ($urandom_range(0, 3) != 0)
			return $urandom_range(1, 6);
		return (lim < 16) ? lim + $urandom_range(1, 3) : $urandom_range(7, 24);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		text_ch.valid <= 1'b1;
		text_ch.in_byte <= b;
		do @(posedge clk); while (!text_ch.ready);
		bytes_sent++;
	endtask

	task automatic feed_text();
		while (text_bytes.size() > 0)
			send_byte(text_bytes.pop_front());
		text_ch.valid <= 1'b0;
	endtask

	// pending is updated with a nonblocking assignment in the checker, so wait for the clock before looking at it
	task automatic wait_idle();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LEN_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic build_random(input int n, input int lim);
		int         pick;
		int         len;
		logic [7:0] b;
		while (text_bytes.size() < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				// bare word, first byte must not open a quote or a slash
				do b = rand_word_byte(); while (b == CH_QUOTE || b == CH_SLASH);
				text_bytes.push_back(b);
				len = tok_len(lim);
				repeat (len - 1) text_bytes.push_back(rand_word_byte());
				text_bytes.push_back(rand_blank());
			end else if (pick < 55) begin
				text_bytes.push_back(CH_QUOTE);
				len = ($urandom_range(0, 5) == 0) ? 0 : tok_len(lim);
				repeat (len) begin
					do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
					text_bytes.push_back(b);
				end
				text_bytes.push_back(CH_QUOTE);
			end else if (pick < 64) begin
				text_bytes.push_back(CH_SLASH);
				text_bytes.push_back(CH_SLASH);
				repeat ($urandom_range(0, 8)) begin
					do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
					text_bytes.push_back(b);
				end
				text_bytes.push_back(CH_NL);
			end else if (pick < 73) begin
				// block comment, star heavy so star runs show up
				text_bytes.push_back(CH_SLASH);
				text_bytes.push_back(CH_STAR);
				repeat ($urandom_range(0, 8)) begin
					if ($urandom_range(0, 2) == 0)
						b = CH_STAR;
					else
						do b = 8'($urandom_range(1, 255)); while (b == CH_SLASH);
					text_bytes.push_back(b);
				end
				text_bytes.push_back(CH_STAR);
				text_bytes.push_back(CH_SLASH);
			end else if (pick < 81) begin
				repeat ($urandom_range(1, 4)) text_bytes.push_back(rand_blank());
			end else if (pick < 87) begin
				text_bytes.push_back(CH_SLASH);
				repeat (tok_len(lim) - 1) text_bytes.push_back(rand_word_byte());
				text_bytes.push_back(rand_blank());
			end else if (pick < 92) begin
				text_bytes.push_back(CH_EOI);
			end else begin
				repeat ($urandom_range(1, 4)) text_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		text_ch.valid <= 1'b0;
		text_ch.in_byte <= 8'd0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		bytes_sent = 0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass at the reset limit
		text_bytes = '{
			// quoted string with a high byte and a newline, then an empty one
			CH_QUOTE, 8'hFF, CH_NL, CH_QUOTE, CH_QUOTE, CH_QUOTE,
			// lone slash starting a word that a high byte ends
			CH_SLASH, 8'h21, 8'h80,
			// line comment, then a block comment closed after a star run
			CH_SLASH, CH_SLASH, 8'h7A, CH_NL, CH_SLASH, CH_STAR, CH_STAR, CH_STAR, CH_SLASH,
			// word holding a quote and a slash, cut by end of input
			8'h7F, CH_QUOTE, CH_SLASH, CH_EOI,
			// end inside a quote, inside a comment, and right after a held slash
			CH_QUOTE, 8'h71, CH_EOI, CH_SLASH, CH_STAR, CH_EOI, CH_SLASH, CH_EOI
		};
		feed_text();
		wait_idle();

		limit_plan = '{10'd0, 10'd1, 10'd2, 10'd1023, 10'd7, 10'd3};
		limit_plan[N_PASSES - 1] = 10'($urandom_range(3, 60));
		foreach (limit_plan[i]) begin
			write_limit(limit_plan[i]);
			build_random(text_bytes.size() + BYTES_PER_PASS, limit_plan[i]);
			feed_text();
			wait_idle();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d text bytes and checked %0d results", bytes_sent, checked);
		$display("token limits exercised: reset value, then 0, 1, 2, 1023, 7 and %0d",
			limit_plan[N_PASSES - 1]);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
hdl/stok_pkg.sv
hdl/stok_in_if.sv
hdl/stok_out_if.sv
hdl/stok_front.sv
hdl/stok_queue.sv
hdl/stok_back.sv
hdl/script_tokenizer_unit.sv
sim/script_tokenizer_unit_checker.sv
sim/script_tokenizer_unit_test.sv
